// ===== sv/str_pkg.sv =====
// shared types, constants and float helpers for the strided tensor reduce unit
`timescale 1ns / 1ps

package str_pkg;

   // default sizing
   localparam int MAX_RANK_DEF    = 4;
   localparam int EXTENT_BITS_DEF = 16;
   localparam int ADDR_BITS_DEF   = 32;

   // fixed field widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int RANK_W     = 3;
   localparam int PACKED_W   = 64;
   localparam int COUNT_W    = 32;
   localparam int BASE_W     = 32;
   localparam int FP_W       = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OFFSET   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TENSOR_RANK   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENTS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDES       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_COUNT = 3'd4;

   // function codes of the request word
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   // reduce operation codes
   localparam logic [1:0] OP_MAX = 2'd0;
   localparam logic [1:0] OP_MIN = 2'd1;
   localparam logic [1:0] OP_SUM = 2'd2;

   // float constants
   localparam logic [FP_W-1:0] NEG_FLT_MAX = 32'hFF7F_FFFF;
   localparam logic [FP_W-1:0] POS_FLT_MAX = 32'h7F7F_FFFF;
   localparam logic [FP_W-1:0] FP_ZERO     = 32'h0000_0000;
   localparam logic [FP_W-1:0] QNAN        = 32'h7FC0_0000;

   // address generator control
   typedef struct packed {
      logic clear;
      logic advance;
      logic capture;
   } agen_ctl_type;

   // true when p is less than q, false when either is a nan
   function automatic logic fp_less(input logic [FP_W-1:0] p, input logic [FP_W-1:0] q);
      logic nan_p;
      logic nan_q;
      logic lt;
      nan_p = (p[30:23] == 8'hFF) && (p[22:0] != 23'd0);
      nan_q = (q[30:23] == 8'hFF) && (q[22:0] != 23'd0);
      if (nan_p || nan_q) begin
         lt = 1'b0;
      end else if ((p[30:0] == 31'd0) && (q[30:0] == 31'd0)) begin
         lt = 1'b0;
      end else if (p[31] != q[31]) begin
         lt = p[31];
      end else if (!p[31]) begin
         lt = p[30:0] < q[30:0];
      end else begin
         lt = p[30:0] > q[30:0];
      end
      return lt;
   endfunction

endpackage

// ===== sv/str_fadd.sv =====
// two-stage single-precision adder, round to nearest even, subnormals kept
`timescale 1ns / 1ps

module str_fadd
   import str_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  logic [FP_W-1:0] a,
   input  logic [FP_W-1:0] b,
   output logic [FP_W-1:0] sum
);

   // stage one registers
   logic        sign_ff,    sign_in;
   logic [7:0]  exp_ff,     exp_in;
   logic [27:0] mant_ff,    mant_in;
   logic        nan_ff,     nan_in;
   logic        inf_ff,     inf_in;
   logic        infsign_ff, infsign_in;
   logic        zsign_ff,   zsign_in;

   // unpack, order by magnitude, align and add
   logic        nan_a, nan_b, inf_a, inf_b, a_big, sub;
   logic [31:0] big, sml;
   logic [7:0]  eff_x, eff_y, diff;
   logic [4:0]  dsh;
   logic [26:0] ma, t, shf, mask;
   logic        stk;

   always_comb begin
      nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_big  = a[30:0] >= b[30:0];
      big    = a_big ? a : b;
      sml    = a_big ? b : a;
      sub    = a[31] ^ b[31];
      eff_x  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eff_y  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      diff   = eff_x - eff_y;
      dsh    = (diff > 8'd27) ? 5'd27 : diff[4:0];
      ma     = {(big[30:23] != 8'd0), big[22:0], 3'b000};
      t      = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
      shf    = t >> dsh;
      mask   = ~(27'h7FF_FFFF << dsh);
      stk    = |(t & mask);
      mant_in = sub ? ({1'b0, ma} - {1'b0, shf[26:1], shf[0] | stk})
                    : ({1'b0, ma} + {1'b0, shf[26:1], shf[0] | stk});
      sign_in    = big[31];
      exp_in     = eff_x;
      nan_in     = nan_a || nan_b || (inf_a && inf_b && sub);
      inf_in     = inf_a || inf_b;
      infsign_in = inf_a ? a[31] : b[31];
      zsign_in   = sub ? 1'b0 : big[31];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign_ff    <= sign_in;
         exp_ff     <= exp_in;
         mant_ff    <= mant_in;
         nan_ff     <= nan_in;
         inf_ff     <= inf_in;
         infsign_ff <= infsign_in;
         zsign_ff   <= zsign_in;
      end
   end

   // normalize, round and pack
   logic [4:0]  lz, lim, shamt;
   logic [26:0] n;
   logic [8:0]  e9;
   logic [7:0]  efield;
   logic        rup;
   logic [30:0] packed_mag;

   always_comb begin
      lz = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (mant_ff[i]) begin
            lz = 5'(26 - i);
         end
      end
      lim   = (exp_ff > 8'd28) ? 5'd27 : 5'(exp_ff - 8'd1);
      shamt = (lz < lim) ? lz : lim;
      if (mant_ff[27]) begin
         n  = {mant_ff[27:2], |mant_ff[1:0]};
         e9 = {1'b0, exp_ff} + 9'd1;
      end else begin
         n  = mant_ff[26:0] << shamt;
         e9 = {1'b0, exp_ff} - {4'd0, shamt};
      end
      efield     = n[26] ? e9[7:0] : 8'd0;
      rup        = n[2] & (n[1] | n[0] | n[3]);
      packed_mag = {efield, n[25:3]} + {30'd0, rup};
      if (nan_ff) begin
         sum = QNAN;
      end else if (inf_ff) begin
         sum = {infsign_ff, 8'hFF, 23'd0};
      end else if (mant_ff == 28'd0) begin
         sum = {zsign_ff, 31'd0};
      end else if (e9 >= 9'd255) begin
         sum = {sign_ff, 8'hFF, 23'd0};
      end else begin
         sum = {sign_ff, packed_mag};
      end
   end

endmodule

// ===== sv/str_agen.sv =====
// odometer of dimension positions and strided address generation
`timescale 1ns / 1ps

module str_agen
   import str_pkg::*;
#(
   parameter int MAX_RANK    = MAX_RANK_DEF,
   parameter int EXTENT_BITS = EXTENT_BITS_DEF,
   parameter int ADDR_BITS   = ADDR_BITS_DEF
)(
   input  logic                 clock,
   input  logic                 reset,
   input  agen_ctl_type         ctl,
   input  logic [RANK_W-1:0]    rank,
   input  logic [PACKED_W-1:0]  extents,
   input  logic [PACKED_W-1:0]  strides,
   input  logic [BASE_W-1:0]    base,
   output logic [ADDR_BITS-1:0] addr
);

   localparam int PAD_W  = MAX_RANK * EXTENT_BITS + PACKED_W;
   localparam int PROD_W = 2 * EXTENT_BITS;
   localparam int EXT_W  = PROD_W + ADDR_BITS + BASE_W;

   logic [EXTENT_BITS-1:0] pos_ff  [MAX_RANK];
   logic [EXTENT_BITS-1:0] pos_in  [MAX_RANK];
   logic [ADDR_BITS-1:0]   prod_ff [MAX_RANK];
   logic [ADDR_BITS-1:0]   prod_in [MAX_RANK];

   logic [PAD_W-1:0]       ext_pad, str_pad;
   logic [EXTENT_BITS-1:0] ext_d   [MAX_RANK];
   logic [EXTENT_BITS-1:0] str_d   [MAX_RANK];
   logic                   in_use  [MAX_RANK];
   logic [EXTENT_BITS:0]   np      [MAX_RANK];
   logic                   wrap    [MAX_RANK];
   logic                   carry;
   logic [EXT_W-1:0]       wide_prod [MAX_RANK];
   logic [EXT_W-1:0]       base_ext;

   // per-dimension fields and odometer step, last dimension fastest
   always_comb begin
      ext_pad = {{(MAX_RANK * EXTENT_BITS){1'b0}}, extents};
      str_pad = {{(MAX_RANK * EXTENT_BITS){1'b0}}, strides};
      carry   = 1'b1;
      for (int d = 0; d < MAX_RANK; d++) begin
         ext_d[d]  = ext_pad[d*EXTENT_BITS +: EXTENT_BITS];
         str_d[d]  = str_pad[d*EXTENT_BITS +: EXTENT_BITS];
         in_use[d] = {1'b0, rank} > 4'(d);
         np[d]     = {1'b0, pos_ff[d]} + {{EXTENT_BITS{1'b0}}, 1'b1};
         wrap[d]   = (ext_d[d] == '0) || (np[d] >= {1'b0, ext_d[d]});
      end
      for (int d = MAX_RANK - 1; d >= 0; d--) begin
         pos_in[d] = pos_ff[d];
         if (in_use[d] && carry) begin
            pos_in[d] = wrap[d] ? '0 : np[d][EXTENT_BITS-1:0];
            carry     = wrap[d];
         end
         if (ctl.clear) begin
            pos_in[d] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_RANK; d++) begin
            pos_ff[d] <= '0;
         end
      end else if (ctl.clear || ctl.advance) begin
         for (int d = 0; d < MAX_RANK; d++) begin
            pos_ff[d] <= pos_in[d];
         end
      end
   end

   // position times stride, one multiplier per dimension
   always_comb begin
      for (int d = 0; d < MAX_RANK; d++) begin
         wide_prod[d] = EXT_W'(PROD_W'(pos_ff[d]) * PROD_W'(str_d[d]));
         prod_in[d]   = in_use[d] ? wide_prod[d][ADDR_BITS-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         for (int d = 0; d < MAX_RANK; d++) begin
            prod_ff[d] <= prod_in[d];
         end
      end
   end

   // base plus products, wrapping at the address width
   always_comb begin
      base_ext = {{(PROD_W + ADDR_BITS){1'b0}}, base};
      addr     = base_ext[ADDR_BITS-1:0];
      for (int d = 0; d < MAX_RANK; d++) begin
         addr = addr + prod_ff[d];
      end
   end

endmodule

// ===== sv/strided_tensor_reduce_unit.sv =====
// top level of the strided tensor reduce unit: handshake, control and accumulator
// a response word is valid after its request word passes the input, first step, second
// step and output registers; a word is not issued while the one before it is in the
//   first step, for the two-stage float add loop on the accumulator and the odometer
//   feeding the address multipliers; a waiting response word holds issue and both steps
// reset: synchronous, active high; clears control state and loads register defaults
`timescale 1ns / 1ps

module strided_tensor_reduce_unit
   import str_pkg::*;
#(
   parameter int MAX_RANK    = MAX_RANK_DEF,
   parameter int EXTENT_BITS = EXTENT_BITS_DEF,
   parameter int ADDR_BITS   = ADDR_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [1:0]            req_reduce_op,
   input  logic [FP_W-1:0]       req_elem_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_addr_valid,
   output logic [ADDR_BITS-1:0]  rsp_read_addr,
   output logic                  rsp_done_res,
   output logic [FP_W-1:0]       rsp_result,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ADDR,
      KIND_DONE
   } kind_type;

   // configuration registers
   logic [BASE_W-1:0]   base_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic [PACKED_W-1:0] extents_ff;
   logic [PACKED_W-1:0] strides_ff;
   logic [COUNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         rank_ff    <= RANK_W'(1);
         extents_ff <= PACKED_W'(1);
         strides_ff <= PACKED_W'(1);
         count_ff   <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_BASE_OFFSET:   base_ff    <= csr_wdata[BASE_W-1:0];
            CSR_TENSOR_RANK:   rank_ff    <= csr_wdata[RANK_W-1:0];
            CSR_EXTENTS:       extents_ff <= csr_wdata;
            CSR_STRIDES:       strides_ff <= csr_wdata;
            CSR_ELEMENT_COUNT: count_ff   <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic            in_v_ff;
   logic            in_func_ff;
   logic [1:0]      in_op_ff;
   logic [FP_W-1:0] in_val_ff;

   // pipeline and reduction state
   logic            s1_v_ff,   s1_v_in;
   kind_type        s1_kind_ff, s1_kind_in;
   logic            s1_sum_ff, s1_sum_in;
   logic            s2_v_ff,   s2_v_in;
   kind_type        s2_kind_ff;
   logic            busy_ff,   busy_in;
   logic [1:0]      op_ff,     op_in;
   logic [FP_W-1:0] acc_ff,    acc_in;
   logic [COUNT_W-1:0] done_cnt_ff, done_cnt_in;

   logic            stall, issue;
   logic [1:0]      start_op;
   logic [COUNT_W-1:0] cnt_next;
   logic            fold_take;
   logic [FP_W-1:0] fadd_sum;
   logic [ADDR_BITS-1:0] agen_addr;
   agen_ctl_type    agen_ctl;

   assign stall     = rsp_valid && !rsp_ready;
   assign issue     = in_v_ff && !s1_v_ff && !stall;
   assign req_ready = !in_v_ff || issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_v_ff <= 1'b1;
      end else if (issue) begin
         in_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff <= req_func;
         in_op_ff   <= req_reduce_op;
         in_val_ff  <= req_elem_value;
      end
   end

   // first step: start, compare fold or add stage one, odometer step
   always_comb begin
      start_op    = (in_op_ff == OP_MAX || in_op_ff == OP_MIN) ? in_op_ff : OP_SUM;
      cnt_next    = done_cnt_ff + COUNT_W'(1);
      fold_take   = (op_ff == OP_MAX) ? fp_less(acc_ff, in_val_ff)
                                      : fp_less(in_val_ff, acc_ff);
      busy_in     = busy_ff;
      op_in       = op_ff;
      acc_in      = acc_ff;
      done_cnt_in = done_cnt_ff;
      s1_kind_in  = KIND_NONE;
      s1_sum_in   = 1'b0;
      agen_ctl    = '0;
      if (issue) begin
         if (in_func_ff == FUNC_START) begin
            op_in          = start_op;
            acc_in         = (start_op == OP_MAX) ? NEG_FLT_MAX :
                             (start_op == OP_MIN) ? POS_FLT_MAX : FP_ZERO;
            done_cnt_in    = '0;
            agen_ctl.clear = 1'b1;
            busy_in        = count_ff != '0;
            s1_kind_in     = (count_ff == '0) ? KIND_DONE : KIND_ADDR;
         end else if (busy_ff) begin
            if (op_ff == OP_SUM) begin
               s1_sum_in = 1'b1;
            end else if (fold_take) begin
               acc_in = in_val_ff;
            end
            done_cnt_in = cnt_next;
            if (cnt_next >= count_ff) begin
               busy_in    = 1'b0;
               s1_kind_in = KIND_DONE;
            end else begin
               agen_ctl.advance = 1'b1;
               s1_kind_in       = KIND_ADDR;
            end
         end
      end
      // second step: add result into the accumulator, products captured
      if (s1_v_ff && !stall) begin
         agen_ctl.capture = 1'b1;
         if (s1_sum_ff) begin
            acc_in = fadd_sum;
         end
      end
      s1_v_in = issue ? 1'b1 : (stall ? s1_v_ff : 1'b0);
      s2_v_in = stall ? s2_v_ff : s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         busy_ff     <= 1'b0;
         op_ff       <= OP_MAX;
         acc_ff      <= '0;
         done_cnt_ff <= '0;
      end else begin
         s1_v_ff     <= s1_v_in;
         s2_v_ff     <= s2_v_in;
         busy_ff     <= busy_in;
         op_ff       <= op_in;
         acc_ff      <= acc_in;
         done_cnt_ff <= done_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_kind_ff <= s1_kind_in;
         s1_sum_ff  <= s1_sum_in;
      end
      if (s1_v_ff && !stall) begin
         s2_kind_ff <= s1_kind_ff;
      end
   end

   str_fadd u_fadd (
      .clock (clock),
      .en    (issue),
      .a     (acc_ff),
      .b     (in_val_ff),
      .sum   (fadd_sum)
   );

   str_agen #(
      .MAX_RANK    (MAX_RANK),
      .EXTENT_BITS (EXTENT_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_agen (
      .clock   (clock),
      .reset   (reset),
      .ctl     (agen_ctl),
      .rank    (rank_ff),
      .extents (extents_ff),
      .strides (strides_ff),
      .base    (base_ff),
      .addr    (agen_addr)
   );

   // output register
   logic                 rsp_v_ff,     rsp_v_in;
   logic                 rsp_av_ff;
   logic [ADDR_BITS-1:0] rsp_addr_ff;
   logic                 rsp_dn_ff;
   logic [FP_W-1:0]      rsp_res_ff;
   logic                 out_load;

   assign out_load = s2_v_ff && !stall;
   assign rsp_v_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_av_ff   <= s2_kind_ff == KIND_ADDR;
         rsp_addr_ff <= (s2_kind_ff == KIND_ADDR) ? agen_addr : '0;
         rsp_dn_ff   <= s2_kind_ff == KIND_DONE;
         rsp_res_ff  <= (s2_kind_ff == KIND_DONE) ? acc_ff : '0;
      end
   end

   assign rsp_valid      = rsp_v_ff;
   assign rsp_addr_valid = rsp_av_ff;
   assign rsp_read_addr  = rsp_addr_ff;
   assign rsp_done_res   = rsp_dn_ff;
   assign rsp_result     = rsp_res_ff;

   // checks
   a_issue_spacing: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !stall |=> !s1_v_ff)
      else $error("word issued on back to back cycles");

   a_addr_done_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_addr_valid && rsp_done_res))
      else $error("address and result flagged together");

   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      out_load && s2_kind_ff == KIND_DONE && !s1_v_ff |-> !busy_ff)
      else $error("reduction still busy after its result");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      stall |=> rsp_valid && $stable(rsp_result) && $stable(rsp_read_addr))
      else $error("response word changed while stalled");

endmodule
